### rtl/scan_sweep_target_scheduler_macros.svh
// Assertion macros for the checker of the scan sweep target scheduler.
`ifndef SCAN_SWEEP_TARGET_SCHEDULER_MACROS_SVH
`define SCAN_SWEEP_TARGET_SCHEDULER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSTS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// The consequent must hold in the cycle after the antecedent.
`define SSTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

### rtl/ssts_pkg.sv
// Package with the types and constants of the scan sweep target scheduler.
`timescale 1ns / 1ps
`default_nettype none

package ssts_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned POS_WIDTH_DEF   = 12;
  localparam int unsigned TAG_WIDTH       = 8;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_SERVED   = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_SERVE  = 1'b1
  } req_e;

  typedef enum logic {
    Q_UPPER = 1'b0,
    Q_LOWER = 1'b1
  } qsel_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_INS_SCAN,
    S_INS_LAST,
    S_SRV_DATA,
    S_RESP
  } state_e;

endpackage

`default_nettype wire

### rtl/ssts_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module ssts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/scan_sweep_target_scheduler.sv
// Top level of the scan sweep target scheduler (SCAN elevator ordering of targets).
`timescale 1ns / 1ps
`default_nettype none

// The scheduler keeps waiting targets in two sorted queues held in one RAM: the upper
// queue (targets at or above the head position, ascending) and the lower queue
// (targets below it, descending). Each queue is a ring inside its half of the RAM, so
// a serve only reads the entry at the ring head and advances the head pointer. An
// insert walks the target queue from its tail toward its head, one entry per cycle,
// using the single shared position comparator: every entry that comes strictly later
// than the new target is moved one slot back, and the new target lands after all
// entries with an equal position. A beat on the input carries either an insert
// (tuser low) or a serve (tuser high); every input beat produces exactly one output
// beat whose tuser holds the status. The walk is bounded by the one RAM write port
// and the one comparator. The input is not ready while an item is being worked on,
// but a finished result sitting in the output register does not block the next input
// beat. The queue RAM needs no clearing: only entries below the fill counts are read.

module scan_sweep_target_scheduler #(
  parameter int unsigned QUEUE_DEPTH = ssts_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned POS_WIDTH   = ssts_pkg::POS_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  // Request beats.
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // target_pos, job_tag, zero padding.
  input  logic [((POS_WIDTH+ssts_pkg::TAG_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // req_type.
  input  logic s_axis_tuser,
  // Result beats.
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // served_pos, served_tag, sweep_up, zero padding.
  output logic [((POS_WIDTH+ssts_pkg::TAG_WIDTH+1+7)/8)*8-1:0] m_axis_tdata,
  // status.
  output logic [1:0] m_axis_tuser
);

  localparam int unsigned TW       = ssts_pkg::TAG_WIDTH;
  localparam int unsigned EW       = POS_WIDTH + TW;
  localparam int unsigned AW       = $clog2(QUEUE_DEPTH);
  localparam int unsigned AW1      = AW + 1;
  localparam int unsigned CW       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned M_DW     = ((EW + 1 + 7) / 8) * 8;
  localparam int unsigned RAM_DEPTH = 2 * (2 ** AW);

  // Ring pointer helpers; QUEUE_DEPTH need not be a power of two.
  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    if (p == '0) begin
      r = AW'(QUEUE_DEPTH - 1);
    end else begin
      r = p - 1'b1;
    end
    return r;
  endfunction

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    if (p == AW'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  function automatic logic [AW-1:0] ptr_add(input logic [AW-1:0] base,
                                            input logic [CW-1:0] off);
    logic [AW:0] s;
    s = AW1'(base) + AW1'(off);
    if (s >= AW1'(QUEUE_DEPTH)) begin
      s = s - AW1'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  ssts_pkg::state_e  state_q, state_d;
  ssts_pkg::req_e    req_q, req_d;
  ssts_pkg::qsel_e   qsel_q, qsel_d;
  ssts_pkg::status_e res_status_q, res_status_d;

  logic [POS_WIDTH-1:0] pos_q, pos_d;
  logic [TW-1:0]        tag_q, tag_d;
  logic [AW-1:0]        p_q, p_d;
  logic [CW-1:0]        wk_q, wk_d;
  logic [CW-1:0]        cnt_q [2];
  logic [CW-1:0]        cnt_d [2];
  logic [AW-1:0]        hptr_q [2];
  logic [AW-1:0]        hptr_d [2];
  logic [POS_WIDTH-1:0] head_pos_q, head_pos_d;
  logic                 dir_q, dir_d;
  logic [POS_WIDTH-1:0] res_pos_q, res_pos_d;
  logic [TW-1:0]        res_tag_q, res_tag_d;
  logic                 m_valid_q, m_valid_d;
  logic [M_DW-1:0]      m_data_q, m_data_d;
  logic [1:0]           m_user_q, m_user_d;

  // RAM port signals.
  logic          ram_we;
  logic [AW:0]   ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [AW:0]   ram_raddr;
  logic [EW-1:0] rd_data;
  logic [POS_WIDTH-1:0] rd_pos;
  logic [TW-1:0]        rd_tag;

  // Shared comparator.
  logic [POS_WIDTH-1:0] cmp_a, cmp_b;
  logic                 cmp_gt, cmp_lt;

  // Decisions.
  ssts_pkg::qsel_e ins_q, srv_q, dec_q, sel_q;
  logic            new_dir, both_empty, full, later, out_free;
  logic [CW-1:0]   n_cnt;
  logic [AW-1:0]   tail_ptr;

  ssts_ram #(
    .WIDTH (EW),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rd_data)
  );

  assign rd_pos = rd_data[POS_WIDTH-1:0];
  assign rd_tag = rd_data[EW-1:POS_WIDTH];

  // The comparator sorts the new target against a queue entry during the walk, and
  // against the head position when the target queue is chosen.
  always_comb begin
    cmp_b = pos_q;
    if (state_q == ssts_pkg::S_INS_SCAN) begin
      cmp_a = rd_pos;
    end else begin
      cmp_a = head_pos_q;
    end
  end

  assign cmp_gt = (cmp_a > cmp_b);
  assign cmp_lt = (cmp_a < cmp_b);

  assign ins_q      = cmp_gt ? ssts_pkg::Q_LOWER : ssts_pkg::Q_UPPER;
  assign both_empty = (cnt_q[ssts_pkg::Q_UPPER] == '0) && (cnt_q[ssts_pkg::Q_LOWER] == '0);
  // A serve turns around when the queue ahead of the sweep is empty.
  assign new_dir    = dir_q ^ ((dir_q && (cnt_q[ssts_pkg::Q_UPPER] == '0)) ||
                               (!dir_q && (cnt_q[ssts_pkg::Q_LOWER] == '0)));
  assign srv_q      = new_dir ? ssts_pkg::Q_UPPER : ssts_pkg::Q_LOWER;
  assign dec_q      = (req_q == ssts_pkg::REQ_SERVE) ? srv_q : ins_q;
  assign sel_q      = (state_q == ssts_pkg::S_DECIDE) ? dec_q : qsel_q;
  assign n_cnt      = cnt_q[sel_q];
  assign full       = (n_cnt == CW'(QUEUE_DEPTH));
  assign tail_ptr   = ptr_add(hptr_q[sel_q], n_cnt);
  // An entry comes later than the new target in its queue's order.
  assign later      = (qsel_q == ssts_pkg::Q_UPPER) ? cmp_gt : cmp_lt;
  assign out_free   = !m_valid_q || m_axis_tready;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ssts_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ssts_pkg::S_DECIDE;
        end
      end
      ssts_pkg::S_DECIDE: begin
        if (req_q == ssts_pkg::REQ_SERVE) begin
          state_d = both_empty ? ssts_pkg::S_RESP : ssts_pkg::S_SRV_DATA;
        end else if (full || (n_cnt == '0)) begin
          state_d = ssts_pkg::S_RESP;
        end else begin
          state_d = ssts_pkg::S_INS_SCAN;
        end
      end
      ssts_pkg::S_INS_SCAN: begin
        if (!later) begin
          state_d = ssts_pkg::S_RESP;
        end else if (wk_q == CW'(1)) begin
          state_d = ssts_pkg::S_INS_LAST;
        end
      end
      ssts_pkg::S_INS_LAST: state_d = ssts_pkg::S_RESP;
      ssts_pkg::S_SRV_DATA: state_d = ssts_pkg::S_RESP;
      ssts_pkg::S_RESP: begin
        if (out_free) begin
          state_d = ssts_pkg::S_IDLE;
        end
      end
      default: state_d = ssts_pkg::S_IDLE;
    endcase
  end

  // Datapath and RAM control.
  always_comb begin
    req_d        = req_q;
    pos_d        = pos_q;
    tag_d        = tag_q;
    qsel_d       = qsel_q;
    p_d          = p_q;
    wk_d         = wk_q;
    cnt_d        = cnt_q;
    hptr_d       = hptr_q;
    head_pos_d   = head_pos_q;
    dir_d        = dir_q;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    res_tag_d    = res_tag_q;
    m_valid_d    = m_valid_q && !m_axis_tready;
    m_data_d     = m_data_q;
    m_user_d     = m_user_q;
    ram_we       = 1'b0;
    ram_waddr    = {qsel_q, p_q};
    ram_wdata    = {tag_q, pos_q};
    ram_raddr    = {sel_q, ptr_dec(tail_ptr)};

    unique case (state_q)
      ssts_pkg::S_IDLE: begin
        req_d = ssts_pkg::req_e'(s_axis_tuser);
        pos_d = s_axis_tdata[POS_WIDTH-1:0];
        tag_d = s_axis_tdata[EW-1:POS_WIDTH];
      end
      ssts_pkg::S_DECIDE: begin
        qsel_d    = dec_q;
        res_pos_d = '0;
        res_tag_d = '0;
        if (req_q == ssts_pkg::REQ_SERVE) begin
          if (both_empty) begin
            res_status_d = ssts_pkg::ST_EMPTY;
          end else begin
            dir_d        = new_dir;
            res_status_d = ssts_pkg::ST_SERVED;
            ram_raddr    = {srv_q, hptr_q[srv_q]};
          end
        end else if (full) begin
          res_status_d = ssts_pkg::ST_FULL;
        end else begin
          res_status_d = ssts_pkg::ST_INSERTED;
          if (n_cnt == '0) begin
            ram_we        = 1'b1;
            ram_waddr     = {dec_q, hptr_q[dec_q]};
            cnt_d[dec_q]  = n_cnt + 1'b1;
          end else begin
            // Start the walk at the free slot behind the tail.
            p_d  = tail_ptr;
            wk_d = n_cnt;
          end
        end
      end
      ssts_pkg::S_INS_SCAN: begin
        ram_we = 1'b1;
        if (later) begin
          ram_wdata = rd_data;
          p_d       = ptr_dec(p_q);
          wk_d      = wk_q - 1'b1;
          ram_raddr = {qsel_q, ptr_dec(ptr_dec(p_q))};
        end else begin
          cnt_d[qsel_q] = cnt_q[qsel_q] + 1'b1;
        end
      end
      ssts_pkg::S_INS_LAST: begin
        ram_we        = 1'b1;
        cnt_d[qsel_q] = cnt_q[qsel_q] + 1'b1;
      end
      ssts_pkg::S_SRV_DATA: begin
        res_pos_d      = rd_pos;
        res_tag_d      = rd_tag;
        head_pos_d     = rd_pos;
        hptr_d[qsel_q] = ptr_inc(hptr_q[qsel_q]);
        cnt_d[qsel_q]  = cnt_q[qsel_q] - 1'b1;
      end
      ssts_pkg::S_RESP: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = M_DW'({dir_q, res_tag_q, res_pos_q});
          m_user_d  = res_status_q;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ssts_pkg::S_IDLE;
      cnt_q[0]   <= '0;
      cnt_q[1]   <= '0;
      hptr_q[0]  <= '0;
      hptr_q[1]  <= '0;
      head_pos_q <= '0;
      dir_q      <= 1'b1;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      hptr_q     <= hptr_d;
      head_pos_q <= head_pos_d;
      dir_q      <= dir_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    pos_q        <= pos_d;
    tag_q        <= tag_d;
    qsel_q       <= qsel_d;
    p_q          <= p_d;
    wk_q         <= wk_d;
    res_status_q <= res_status_d;
    res_pos_q    <= res_pos_d;
    res_tag_q    <= res_tag_d;
    m_data_q     <= m_data_d;
    m_user_q     <= m_user_d;
  end

  assign s_axis_tready = (state_q == ssts_pkg::S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

`default_nettype wire

### rtl/ssts_chk.sv
// Port-level checker for the scan sweep target scheduler, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

`include "scan_sweep_target_scheduler_macros.svh"

module ssts_chk #(
  parameter int unsigned POS_WIDTH = ssts_pkg::POS_WIDTH_DEF
) (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [((POS_WIDTH+ssts_pkg::TAG_WIDTH+1+7)/8)*8-1:0] m_axis_tdata,
  input logic [1:0] m_axis_tuser
);

  // Each request is worked on alone, so the block is busy right after a beat.
  `SSTS_ASSERT_NEXT(a_busy_after_beat, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // A stalled result must not change.
  `SSTS_ASSERT_NEXT(a_result_held, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // Only a served result carries a position and a tag.
  `SSTS_ASSERT_SAME(a_no_data_unless_served, m_axis_tvalid && (m_axis_tuser != ssts_pkg::ST_SERVED), m_axis_tdata[POS_WIDTH+ssts_pkg::TAG_WIDTH-1:0] == '0)

endmodule

bind scan_sweep_target_scheduler ssts_chk #(
  .POS_WIDTH (POS_WIDTH)
) u_ssts_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
